[rtl/flow_pulse_totalizer_rate_macros.svh]
// Assertion macros shared by the flow totalizer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FLOW_PULSE_TOTALIZER_RATE_MACROS_SVH
`define FLOW_PULSE_TOTALIZER_RATE_MACROS_SVH
`ifndef ASSERT_OFF
// Expression holds at every clock edge outside reset.
`define FPTR_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fptr assertion failed");
// Antecedent implies consequent in the same cycle.
`define FPTR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fptr implication failed");
// Antecedent implies consequent in the next cycle.
`define FPTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fptr next-cycle check failed");
`else
`define FPTR_ASSERT(label, clk, rst_n, expr)
`define FPTR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FPTR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/fptr_pkg.sv]
// Package for the flow totalizer: payload structs, command/status structs,
// controller states and arithmetic constants. No dependencies.
`default_nettype none

package fptr_pkg;

    // Ring depth default.
    localparam int RING_DEPTH_DEF = 8;

    // Field widths.
    localparam int CNT_W      = 32;
    localparam int TIME_W     = 32;
    localparam int PPG_W      = 24;
    localparam int INTERVAL_W = 16;
    localparam int OUT_W      = 40;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PPG      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTERVAL = 2'd1;
    localparam logic [PPG_W-1:0]      PPG_RESET      = 24'd256;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;

    // Opcodes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    // Divider geometry: 64-bit dividend, 56-bit divisor, 40-bit quotient.
    localparam int DIV_NUM_W   = 64;
    localparam int DIV_DEN_W   = 56;
    localparam int DIV_STEPS   = OUT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int FRAC_SHIFT  = 16;
    localparam int MS_PER_MIN_W = 16;
    localparam logic [MS_PER_MIN_W-1:0] MS_PER_MIN = 16'd60000;
    localparam int DP_PROD_W   = CNT_W + MS_PER_MIN_W;

    typedef struct packed {
        logic              opcode;
        logic [CNT_W-1:0]  pulse_count;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] gallons_q8;
        logic [OUT_W-1:0] rate_gpm_q8;
        logic             saturated;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAL_GO,
        S_GAL_WAIT,
        S_MUL,
        S_RATE_GO,
        S_RATE_WAIT,
        S_FIN
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_sel_rate;
        logic gal_load;
        logic mul_load;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic div_done;
        logic rate_ok;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/fptr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fptr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[rtl/fptr_div.sv]
// Restoring divider, one quotient bit per cycle, with an up-front overflow test
// that clips quotients of 2^40 and above. Depends on fptr_pkg and the macro header.
`default_nettype none
`include "flow_pulse_totalizer_rate_macros.svh"

module fptr_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [fptr_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [fptr_pkg::DIV_DEN_W-1:0] i_den,
    output logic                                o_done,
    output logic      [fptr_pkg::OUT_W-1:0]     o_quot,
    output logic                                o_ovf
);

    localparam int NUM_W = fptr_pkg::DIV_NUM_W;
    localparam int DEN_W = fptr_pkg::DIV_DEN_W;
    localparam int Q_W   = fptr_pkg::OUT_W;
    localparam int HI_W  = NUM_W - Q_W;

    logic                           r_busy;
    logic                           r_done;
    logic                           r_ovf;
    logic [fptr_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]               r_rem;
    logic [DEN_W-1:0]               r_den;
    logic [Q_W-1:0]                 r_nq;

    logic             start_ovf;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_diff;
    logic             trial_ge;

    // The quotient overflows 40 bits exactly when the top dividend bits reach the divisor.
    assign start_ovf = ({{(DEN_W-HI_W){1'b0}}, i_num[NUM_W-1:Q_W]} >= i_den);

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign trial      = {r_rem, r_nq[Q_W-1]};
    assign trial_diff = trial - {1'b0, r_den};
    assign trial_ge   = (trial >= {1'b0, r_den});

    // Control: busy flag, step count and the one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !start_ovf;
                r_done <= start_ovf;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fptr_pkg::DIV_CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, divisor and the shared dividend/quotient register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= start_ovf;
            r_den <= i_den;
            r_rem <= {{(DEN_W-HI_W){1'b0}}, i_num[NUM_W-1:Q_W]};
            r_nq  <= start_ovf ? {Q_W{1'b1}} : i_num[Q_W-1:0];
        end else if (r_busy) begin
            r_rem <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_nq  <= {r_nq[Q_W-2:0], trial_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;
    assign o_ovf  = r_ovf;

    `FPTR_ASSERT_IMPL(a_start_when_idle, i_clk, i_rst_n, i_start, !r_busy)
    `FPTR_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done)

endmodule

`default_nettype wire

[rtl/fptr_datapath.sv]
// Datapath of the flow totalizer: configuration, baseline and ring state,
// sample RAM, multipliers, shared divider and output register.
// Depends on fptr_pkg, fptr_ram, fptr_div and the macro header.
`default_nettype none
`include "flow_pulse_totalizer_rate_macros.svh"

module fptr_datapath #(
    parameter int RING_DEPTH = fptr_pkg::RING_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fptr_pkg::t_dp_cmd               i_cmd,
    output fptr_pkg::t_dp_status                 o_status,
    input  wire fptr_pkg::t_in_item              i_in_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [fptr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fptr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output fptr_pkg::t_out_item                  o_out_data
);

    localparam int HEAD_W = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int CNT_W  = fptr_pkg::CNT_W;
    localparam int TIME_W = fptr_pkg::TIME_W;
    localparam int ENT_W  = TIME_W + CNT_W;
    localparam int OUT_W  = fptr_pkg::OUT_W;
    localparam int NUM_W  = fptr_pkg::DIV_NUM_W;
    localparam int DEN_W  = fptr_pkg::DIV_DEN_W;
    localparam int FS     = fptr_pkg::FRAC_SHIFT;

    // Configuration registers.
    logic [fptr_pkg::PPG_W-1:0]      r_ppg;
    logic [fptr_pkg::INTERVAL_W-1:0] r_interval;

    // Totalizer and ring bookkeeping.
    logic [CNT_W-1:0]  r_baseline;
    logic [CNT_W-1:0]  r_latest;
    logic [CNT_W-1:0]  r_newest_cnt;
    logic [TIME_W-1:0] r_last_time;
    logic [HEAD_W-1:0] r_head;
    logic [FILL_W-1:0] r_fill;

    // Arithmetic holding registers.
    logic [OUT_W-1:0]                 r_gal;
    logic                             r_gal_sat;
    logic [fptr_pkg::DP_PROD_W-1:0]   r_prod_dp;
    logic [DEN_W-1:0]                 r_prod_den;
    logic                             r_rate_ok;

    // Output register.
    logic                r_out_valid;
    fptr_pkg::t_out_item r_out;

    logic [HEAD_W-1:0] head_inc;
    logic              tick_push;
    logic              push;
    logic [HEAD_W-1:0] wr_addr;
    logic [HEAD_W-1:0] oldest_idx;
    logic [ENT_W-1:0]  oldest_ent;
    logic [TIME_W-1:0] dt;
    logic [CNT_W-1:0]  dp;
    logic [CNT_W-1:0]  dg;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [OUT_W-1:0]  div_quot;
    logic              div_ovf;
    logic              out_free;

    // Configuration writes; a zero meter constant is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppg      <= fptr_pkg::PPG_RESET;
            r_interval <= fptr_pkg::INTERVAL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fptr_pkg::CFG_IDX_PPG) begin
                if (i_cfg_data != '0) begin
                    r_ppg <= i_cfg_data[fptr_pkg::PPG_W-1:0];
                end
            end else if (i_cfg_index == fptr_pkg::CFG_IDX_INTERVAL) begin
                r_interval <= i_cfg_data[fptr_pkg::INTERVAL_W-1:0];
            end
        end
    end

    // Push decision for an accepted beat.
    assign head_inc  = (r_head == HEAD_W'(RING_DEPTH - 1)) ? '0 : r_head + HEAD_W'(1);
    assign tick_push = (r_fill == '0) ||
                       ((i_in_data.now_ms - r_last_time) >= {16'b0, r_interval});
    assign push      = i_cmd.accept &&
                       ((i_in_data.opcode == fptr_pkg::OP_RESET) || tick_push);
    assign wr_addr   = (i_in_data.opcode == fptr_pkg::OP_RESET) ? '0 : r_head;

    // Baseline, latest count and ring pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline   <= '0;
            r_latest     <= '0;
            r_newest_cnt <= '0;
            r_last_time  <= '0;
            r_head       <= '0;
            r_fill       <= '0;
        end else if (i_cmd.accept) begin
            r_latest <= i_in_data.pulse_count;
            if (i_in_data.opcode == fptr_pkg::OP_RESET) begin
                r_baseline   <= i_in_data.pulse_count;
                r_newest_cnt <= i_in_data.pulse_count;
                r_last_time  <= i_in_data.now_ms;
                r_head       <= HEAD_W'(1);
                r_fill       <= FILL_W'(1);
            end else if (tick_push) begin
                r_newest_cnt <= i_in_data.pulse_count;
                r_last_time  <= i_in_data.now_ms;
                r_head       <= head_inc;
                if (r_fill != FILL_W'(RING_DEPTH)) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    // The oldest sample is entry 0 until the ring wraps, then the head entry.
    assign oldest_idx = (r_fill == FILL_W'(RING_DEPTH)) ? r_head : '0;

    fptr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (push),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_in_data.now_ms, i_in_data.pulse_count}),
        .i_rd_addr (oldest_idx),
        .o_rd_data (oldest_ent)
    );

    // Differences between the newest sample and the oldest one, and the count since the baseline.
    assign dt = r_last_time - oldest_ent[ENT_W-1:CNT_W];
    assign dp = r_newest_cnt - oldest_ent[CNT_W-1:0];
    assign dg = r_latest - r_baseline;

    // Rate products: dp * 60000 and K * dt.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_prod_dp  <= fptr_pkg::DP_PROD_W'(dp) *
                          fptr_pkg::DP_PROD_W'(fptr_pkg::MS_PER_MIN);
            r_prod_den <= DEN_W'(r_ppg) * DEN_W'(dt);
            r_rate_ok  <= o_status.rate_ok;
        end
    end

    // Divider operands: gallons first, then the rate.
    assign div_num = i_cmd.div_sel_rate ? {r_prod_dp, {FS{1'b0}}}
                                        : {{(NUM_W-CNT_W-FS){1'b0}}, dg, {FS{1'b0}}};
    assign div_den = i_cmd.div_sel_rate ? r_prod_den
                                        : {{(DEN_W-fptr_pkg::PPG_W){1'b0}}, r_ppg};

    fptr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    // Gallons result is parked while the rate division runs.
    always_ff @(posedge i_clk) begin
        if (i_cmd.gal_load) begin
            r_gal     <= div_quot;
            r_gal_sat <= div_ovf;
        end
    end

    // Output register; it frees up when the current beat is taken.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.gallons_q8  <= r_gal;
            r_out.rate_gpm_q8 <= r_rate_ok ? div_quot : '0;
            r_out.saturated   <= r_gal_sat || (r_rate_ok && div_ovf);
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.rate_ok  = (r_fill >= FILL_W'(2)) && (dt != '0);
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    `FPTR_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(RING_DEPTH))
    `FPTR_ASSERT(a_head_wraps, i_clk, i_rst_n, r_head <= HEAD_W'(RING_DEPTH - 1))
    `FPTR_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load, out_free)

endmodule

`default_nettype wire

[rtl/fptr_ctrl.sv]
// Controller of the flow totalizer: sequences accept, gallons division,
// rate products, rate division and the output load. Depends on fptr_pkg and macros.
`default_nettype none
`include "flow_pulse_totalizer_rate_macros.svh"

module fptr_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire fptr_pkg::t_dp_status i_status,
    output fptr_pkg::t_dp_cmd         o_cmd
);

    fptr_pkg::t_state r_state;
    fptr_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fptr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fptr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = fptr_pkg::S_GAL_GO;
            end
            fptr_pkg::S_GAL_GO: begin
                n_state = fptr_pkg::S_GAL_WAIT;
            end
            fptr_pkg::S_GAL_WAIT: begin
                if (i_status.div_done) n_state = fptr_pkg::S_MUL;
            end
            fptr_pkg::S_MUL: begin
                n_state = i_status.rate_ok ? fptr_pkg::S_RATE_GO : fptr_pkg::S_FIN;
            end
            fptr_pkg::S_RATE_GO: begin
                n_state = fptr_pkg::S_RATE_WAIT;
            end
            fptr_pkg::S_RATE_WAIT: begin
                if (i_status.div_done) n_state = fptr_pkg::S_FIN;
            end
            fptr_pkg::S_FIN: begin
                if (i_status.out_free) n_state = fptr_pkg::S_IDLE;
            end
            default: begin
                n_state = fptr_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            fptr_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            fptr_pkg::S_GAL_GO: begin
                o_cmd.div_start = 1'b1;
            end
            fptr_pkg::S_GAL_WAIT: begin
                o_cmd.gal_load = i_status.div_done;
            end
            fptr_pkg::S_MUL: begin
                o_cmd.mul_load = 1'b1;
            end
            fptr_pkg::S_RATE_GO: begin
                o_cmd.div_start    = 1'b1;
                o_cmd.div_sel_rate = 1'b1;
            end
            fptr_pkg::S_RATE_WAIT: begin
                o_cmd.div_sel_rate = 1'b1;
            end
            fptr_pkg::S_FIN: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `FPTR_ASSERT_IMPL(a_done_while_waiting, i_clk, i_rst_n, i_status.div_done, r_state == fptr_pkg::S_GAL_WAIT || r_state == fptr_pkg::S_RATE_WAIT)

endmodule

`default_nettype wire

[rtl/flow_pulse_totalizer_rate.sv]
// Top level of the pulse flow meter totalizer with windowed flow rate.
// Depends on fptr_pkg, fptr_ctrl and fptr_datapath.
//
// The block takes one beat at a time: a tick or a baseline reset carrying a
// 32-bit pulse count and a millisecond timestamp, and returns one beat with
// gallons since the baseline and the flow rate between the oldest and newest
// samples of the ring, both Q.8 and clipped at 2^40-1 with a flag. Both results
// come out of one shared divider that retires a quotient bit per cycle, so the
// result of an item is loaded into the output register once its divisions end,
// later while the receiver leaves the previous result stalled there, and the next
// item is taken the cycle after that load, never while one is in flight. A clipped
// quotient ends its division at once, and when fewer than two samples are held or
// the time span is zero the rate division is skipped. The sample ring needs no
// clearing after reset. Configuration writes are always taken.
`default_nettype none

module flow_pulse_totalizer_rate #(
    parameter int RING_DEPTH = fptr_pkg::RING_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire fptr_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output fptr_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fptr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fptr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fptr_pkg::t_dp_cmd    cmd;
    fptr_pkg::t_dp_status status;

    // Registers accept a write in any cycle.
    assign o_cfg_ready = 1'b1;

    fptr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fptr_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
